### design/bad_pkg.sv
`default_nettype none
package bad_pkg;

    localparam int MAX_DST_WIDTH = 4096;
    localparam int MAX_SRC_DIM   = 4096;

    localparam int DIM_W   = 13;                      // 1..4096
    localparam int POS_W   = 12;                      // 0..4095
    localparam int ADDR_W  = $clog2(MAX_DST_WIDTH);
    localparam int SUM_W   = 32;
    localparam int AREA_W  = 2 * DIM_W - 1;           // up to 4096 * 4096
    localparam int AVG_W   = 16;
    localparam int FRAC_W  = 8;
    localparam int DVD_W   = SUM_W + FRAC_W;
    localparam int CFG_IDX_W = 3;
    localparam int NUM_CH  = 3;

    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 3'd3;

    typedef enum logic [2:0] {
        ST_SETUP,
        ST_IDLE,
        ST_UPD,
        ST_DIV,
        ST_HOLD
    } state_t;

    typedef logic [SUM_W-1:0] sum_t;
    typedef logic [AVG_W-1:0] avg_t;

    typedef struct packed {
        logic start;
        logic done;
        logic busy;
    } div_ctrl_t;

endpackage
`default_nettype wire

### design/bad_pix_if.sv
`default_nettype none
interface bad_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;

    modport source (output valid, red_in, green_in, blue_in, input ready);
    modport sink   (input valid, red_in, green_in, blue_in, output ready);
endinterface
`default_nettype wire

### design/bad_res_if.sv
`default_nettype none
interface bad_res_if;
    logic        valid;
    logic        ready;
    logic [15:0] red_avg;
    logic [15:0] green_avg;
    logic [15:0] blue_avg;
    logic [11:0] out_col;
    logic [11:0] out_row;
    logic        frame_last;

    modport source (output valid, red_avg, green_avg, blue_avg, out_col, out_row,
                    frame_last, input ready);
    modport sink   (input valid, red_avg, green_avg, blue_avg, out_col, out_row,
                    frame_last, output ready);
endinterface
`default_nettype wire

### design/box_average_downscaler_core.sv
// Channel  Dir  Words                        Handshake
// cfg      in   cfg_index, cfg_data          cfg_we, always taken
// pix      in   red_in, green_in, blue_in    valid / ready
// res      out  *_avg, out_col, out_row,     valid / ready
//              frame_last
// After reset and after every write to a size register the block works out
// the block size and area, with pix.ready low.
// A pixel goes through the sum memory read, then the add and write back.
// A pixel that closes a block then also takes the 40 mean divider steps,
// the divider's done pulse and the load of the output register.
// A result waits in the output register; the block stalls only if a second
// result is ready before the first is taken.
`default_nettype none
module box_average_downscaler_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [bad_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [bad_pkg::DIM_W-1:0]     cfg_data,
    bad_pix_if.sink                            pix,
    bad_res_if.source                          res
);
    import bad_pkg::*;

    localparam int SCNT_W = 4;
    localparam logic [SCNT_W-1:0] SETUP_LAST = SCNT_W'(DIM_W + 1);

    // Configuration registers.
    logic [DIM_W-1:0] src_width_reg, src_height_reg, dst_width_reg, dst_height_reg;
    logic             cfg_hit;

    assign cfg_hit = cfg_we && (cfg_index == REG_SRC_WIDTH || cfg_index == REG_SRC_HEIGHT
                     || cfg_index == REG_DST_WIDTH || cfg_index == REG_DST_HEIGHT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg  <= DIM_W'(640);
            src_height_reg <= DIM_W'(480);
            dst_width_reg  <= DIM_W'(320);
            dst_height_reg <= DIM_W'(240);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SRC_WIDTH:  src_width_reg  <= cfg_data;
                REG_SRC_HEIGHT: src_height_reg <= cfg_data;
                REG_DST_WIDTH:  dst_width_reg  <= cfg_data;
                REG_DST_HEIGHT: dst_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Saturated sizes.
    logic [DIM_W-1:0] sw_c, sh_c, dw_c, dh_c;
    always_comb
    begin
        sw_c = (src_width_reg == '0) ? DIM_W'(1) :
               (src_width_reg > DIM_W'(MAX_SRC_DIM)) ? DIM_W'(MAX_SRC_DIM) : src_width_reg;
        sh_c = (src_height_reg == '0) ? DIM_W'(1) :
               (src_height_reg > DIM_W'(MAX_SRC_DIM)) ? DIM_W'(MAX_SRC_DIM) : src_height_reg;
        dw_c = (dst_width_reg == '0) ? DIM_W'(1) : dst_width_reg;
        if (dw_c > sw_c)
            dw_c = sw_c;
        if (dw_c > DIM_W'(MAX_DST_WIDTH))
            dw_c = DIM_W'(MAX_DST_WIDTH);
        dh_c = (dst_height_reg == '0) ? DIM_W'(1) : dst_height_reg;
        if (dh_c > sh_c)
            dh_c = sh_c;
    end

    state_t state_reg, state_next;
    logic [SCNT_W-1:0] scnt_reg;

    // Frame geometry, fixed between register writes.
    logic [DIM_W-1:0]  sw_reg, sh_reg, dw_reg, dh_reg;
    logic [DIM_W-1:0]  bw_reg, bwm_reg, bh_reg, bhm_reg;
    logic [AREA_W-1:0] area_reg;

    // Setup dividers: sw / dw and sh / dh, one bit a cycle.
    logic [DIM_W:0] remw_s, remh_s;
    logic           fitw, fith;
    assign remw_s = {bwm_reg, bw_reg[DIM_W-1]};
    assign remh_s = {bhm_reg, bh_reg[DIM_W-1]};
    assign fitw   = remw_s >= {1'b0, dw_reg};
    assign fith   = remh_s >= {1'b0, dh_reg};

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_SETUP)
        begin
            if (scnt_reg == '0)
            begin
                sw_reg  <= sw_c;
                sh_reg  <= sh_c;
                dw_reg  <= dw_c;
                dh_reg  <= dh_c;
                bw_reg  <= sw_c;
                bh_reg  <= sh_c;
                bwm_reg <= '0;
                bhm_reg <= '0;
            end
            else if (scnt_reg != SETUP_LAST)
            begin
                bw_reg  <= {bw_reg[DIM_W-2:0], fitw};
                bh_reg  <= {bh_reg[DIM_W-2:0], fith};
                bwm_reg <= fitw ? DIM_W'(remw_s - {1'b0, dw_reg}) : remw_s[DIM_W-1:0];
                bhm_reg <= fith ? DIM_W'(remh_s - {1'b0, dh_reg}) : remh_s[DIM_W-1:0];
            end
            else
            begin
                area_reg <= AREA_W'(bw_reg) * AREA_W'(bh_reg);
            end
        end
    end

    // Scan position and current block bounds.
    logic [POS_W-1:0] col_reg, row_reg;
    logic [DIM_W-1:0] k_reg, bri_reg, cb_reg, cbr_reg, rb_reg, rbr_reg;

    logic [DIM_W:0] cb_end, rb_end, cr_sum, rr_sum;
    logic [DIM_W:0] col_x, row_x;
    logic           col_in, col_lastb, row_ok, row_last, line_end, frame_end, accept;
    logic           wr_c, first_c, emit_c;

    assign accept  = pix.valid && pix.ready;
    assign cb_end  = {1'b0, cb_reg} + {1'b0, bw_reg};
    assign rb_end  = {1'b0, rb_reg} + {1'b0, bh_reg};
    assign cr_sum  = {1'b0, cbr_reg} + {1'b0, bwm_reg};
    assign rr_sum  = {1'b0, rbr_reg} + {1'b0, bhm_reg};
    assign col_x   = {2'b00, col_reg};
    assign row_x   = {2'b00, row_reg};

    assign col_in    = (k_reg < dw_reg) && (col_x >= {1'b0, cb_reg}) && (col_x < cb_end);
    assign col_lastb = col_x == cb_end - 1'b1;
    assign row_ok    = (bri_reg < dh_reg) && (row_x >= {1'b0, rb_reg}) && (row_x < rb_end);
    assign row_last  = (bri_reg < dh_reg) && (row_x == rb_end - 1'b1);
    assign line_end  = {1'b0, col_reg} >= sw_reg - 1'b1;
    assign frame_end = {1'b0, row_reg} >= sh_reg - 1'b1;
    assign wr_c      = col_in && row_ok;
    assign first_c   = (row_x == {1'b0, rb_reg}) && (col_x == {1'b0, cb_reg});
    assign emit_c    = wr_c && row_last && col_lastb;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
            k_reg   <= '0;
            bri_reg <= '0;
            cb_reg  <= '0;
            cbr_reg <= '0;
            rb_reg  <= '0;
            rbr_reg <= '0;
        end
        else if (cfg_hit)
        begin
            col_reg <= '0;
            row_reg <= '0;
            k_reg   <= '0;
            bri_reg <= '0;
            cb_reg  <= '0;
            cbr_reg <= '0;
            rb_reg  <= '0;
            rbr_reg <= '0;
        end
        else if (accept)
        begin
            // Block origins advance by the quotient, plus one when the
            // running remainder wraps past the divisor.
            if (col_in && col_lastb)
            begin
                k_reg <= k_reg + 1'b1;
                if (cr_sum >= {1'b0, dw_reg})
                begin
                    cb_reg  <= DIM_W'(cb_end + 1'b1);
                    cbr_reg <= DIM_W'(cr_sum - {1'b0, dw_reg});
                end
                else
                begin
                    cb_reg  <= cb_end[DIM_W-1:0];
                    cbr_reg <= cr_sum[DIM_W-1:0];
                end
            end
            if (!line_end)
            begin
                col_reg <= col_reg + 1'b1;
            end
            else
            begin
                col_reg <= '0;
                k_reg   <= '0;
                cb_reg  <= '0;
                cbr_reg <= '0;
                if (frame_end)
                begin
                    row_reg <= '0;
                    bri_reg <= '0;
                    rb_reg  <= '0;
                    rbr_reg <= '0;
                end
                else
                begin
                    row_reg <= row_reg + 1'b1;
                    if (row_last)
                    begin
                        bri_reg <= bri_reg + 1'b1;
                        if (rr_sum >= {1'b0, dh_reg})
                        begin
                            rb_reg  <= DIM_W'(rb_end + 1'b1);
                            rbr_reg <= DIM_W'(rr_sum - {1'b0, dh_reg});
                        end
                        else
                        begin
                            rb_reg  <= rb_end[DIM_W-1:0];
                            rbr_reg <= rr_sum[DIM_W-1:0];
                        end
                    end
                end
            end
        end
    end

    // Per-pixel work held for the write-back cycle.
    logic              wr_reg, first_reg, emit_reg, last_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [7:0]        r_reg, g_reg, b_reg;
    logic [POS_W-1:0]  ocol_reg, orow_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            addr_reg  <= k_reg[ADDR_W-1:0];
            first_reg <= first_c;
            r_reg     <= pix.red_in;
            g_reg     <= pix.green_in;
            b_reg     <= pix.blue_in;
            if (emit_c)
            begin
                ocol_reg <= k_reg[POS_W-1:0];
                orow_reg <= bri_reg[POS_W-1:0];
                last_reg <= (k_reg == dw_reg - 1'b1) && (bri_reg == dh_reg - 1'b1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg   <= 1'b0;
            emit_reg <= 1'b0;
        end
        else
        begin
            wr_reg   <= accept && wr_c;
            emit_reg <= accept && emit_c;
        end
    end

    // Column sum memory: red, green, blue packed in one word.
    logic [NUM_CH*SUM_W-1:0] sum_mem [MAX_DST_WIDTH];
    logic [NUM_CH*SUM_W-1:0] rd_reg;
    sum_t                    new_sum [NUM_CH];

    always_ff @(posedge clk)
    begin
        if (accept)
            rd_reg <= sum_mem[k_reg[ADDR_W-1:0]];
        if (wr_reg)
            sum_mem[addr_reg] <= {new_sum[2], new_sum[1], new_sum[0]};
    end

    always_comb
    begin
        new_sum[0] = (first_reg ? '0 : rd_reg[SUM_W-1:0])         + SUM_W'(r_reg);
        new_sum[1] = (first_reg ? '0 : rd_reg[2*SUM_W-1:SUM_W])   + SUM_W'(g_reg);
        new_sum[2] = (first_reg ? '0 : rd_reg[3*SUM_W-1:2*SUM_W]) + SUM_W'(b_reg);
    end

    div_ctrl_t div_ctrl;
    avg_t      avgs [NUM_CH];

    bad_mean_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (emit_reg),
        .sums  (new_sum),
        .area  (area_reg),
        .ctrl  (div_ctrl),
        .avgs  (avgs)
    );

    // Output register.
    logic res_valid_reg, load_out;
    assign load_out = (state_reg == ST_HOLD) && (!res_valid_reg || res.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (load_out)
            res_valid_reg <= 1'b1;
        else if (res.ready)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            res.red_avg    <= avgs[0];
            res.green_avg  <= avgs[1];
            res.blue_avg   <= avgs[2];
            res.out_col    <= ocol_reg;
            res.out_row    <= orow_reg;
            res.frame_last <= last_reg;
        end
    end

    assign res.valid = res_valid_reg;
    assign pix.ready = state_reg == ST_IDLE;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_SETUP;
            scnt_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_hit || state_reg != ST_SETUP)
                scnt_reg <= '0;
            else
                scnt_reg <= scnt_reg + 1'b1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_SETUP: if (scnt_reg == SETUP_LAST) state_next = ST_IDLE;
            ST_IDLE:  if (accept) state_next = ST_UPD;
            ST_UPD:   state_next = emit_reg ? ST_DIV : ST_IDLE;
            ST_DIV:   if (div_ctrl.done) state_next = ST_HOLD;
            ST_HOLD:  if (load_out) state_next = ST_IDLE;
            default:  state_next = ST_SETUP;
        endcase
        if (cfg_hit)
            state_next = ST_SETUP;
    end

    a_upd_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_UPD |-> $past(accept)) else $error("update without a word");
    a_emit_to_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPD && emit_reg && !cfg_hit) |=> div_ctrl.busy)
        else $error("closing pixel did not start the divider");
    a_last_col: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.frame_last) |-> ({1'b0, res.out_col} == dw_reg - 1'b1))
        else $error("frame end flagged away from the last column");

endmodule
`default_nettype wire

### design/bad_mean_div.sv
`default_nettype none
module bad_mean_div (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire bad_pkg::sum_t            sums [bad_pkg::NUM_CH],
    input  wire logic [bad_pkg::AREA_W-1:0] area,
    output bad_pkg::div_ctrl_t            ctrl,
    output bad_pkg::avg_t                 avgs [bad_pkg::NUM_CH]
);
    import bad_pkg::*;

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DVD_W-1:0]  dvd_reg [NUM_CH];
    logic [AREA_W-1:0] rem_reg [NUM_CH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg  <= CNT_W'(DVD_W);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // One restoring step per cycle: the dividend shifts out at the top while
    // quotient bits shift in at the bottom.
    for (genvar c = 0; c < NUM_CH; c++)
    begin : g_lane
        logic [AREA_W:0] rem_s;
        logic            fits;

        assign rem_s = {rem_reg[c], dvd_reg[c][DVD_W-1]};
        assign fits  = rem_s >= {1'b0, area};

        always_ff @(posedge clk)
        begin
            if (start)
            begin
                dvd_reg[c] <= {sums[c], {FRAC_W{1'b0}}};
                rem_reg[c] <= '0;
            end
            else if (busy_reg)
            begin
                dvd_reg[c] <= {dvd_reg[c][DVD_W-2:0], fits};
                rem_reg[c] <= fits ? AREA_W'(rem_s - {1'b0, area}) : rem_s[AREA_W-1:0];
            end
        end

        assign avgs[c] = dvd_reg[c][AVG_W-1:0];
    end

    assign ctrl.start = start;
    assign ctrl.done  = done_reg;
    assign ctrl.busy  = busy_reg;

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !start) else $error("mean divider restarted while busy");
    a_done_len: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg) && !busy_reg) else $error("done without a run");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg) else $error("done held longer than one cycle");

endmodule
`default_nettype wire
